// ===== hw/rtl/tsp_pkg.sv =====
// Shared types and constants for the timer slot pool.
package tsp_pkg;

   // Field widths
   localparam int TICK_W     = 16;
   localparam int HANDLER_W  = 8;
   localparam int TAG_W      = 32;
   localparam int SLOT_W     = 6;
   localparam int OPCODE_W   = 2;
   localparam int KIND_W     = 2;

   // Default pool size
   localparam int SLOT_COUNT_DEF = 16;

   // Request opcodes (the remaining code is ignored)
   localparam logic [OPCODE_W-1:0] OP_START  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd3;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_SLOT = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CANCEL,
      ST_TICK_SCAN,
      ST_TICK_DONE
   } state_type;

   // One stored timer slot
   typedef struct packed {
      logic [TICK_W-1:0]    expiry;
      logic [HANDLER_W-1:0] handler;
      logic [TAG_W-1:0]     tag;
   } slot_entry_type;

   // One response word
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic                 status;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLER_W-1:0] handler;
      logic [TAG_W-1:0]     tag;
      logic                 last;
   } rsp_word_type;

endpackage

// ===== hw/rtl/timer_slot_pool_unit.sv =====
// Timer slot pool top level: sequencer, busy bits and response register.
//
// Requests arrive on the req_ channel (valid/stall); each carries an opcode:
// start a timer, cancel a slot, or one tick elapsed. Responses leave on the
// rsp_ channel, one word per handshake, with rsp_last set on the final word
// of a request. A start replies with the lowest free slot (or no-slot
// status); a cancel replies with success; a tick advances the 16-bit count,
// sends one expiry word per matching busy slot in ascending order, then a
// tick-done word. An ignored opcode is taken and produces no word.
// One request is handled at a time; req_stall is high while it is in work.
// A slot scanner steps one slot per cycle and shares the expiry compare:
// start scans up to the lowest free slot, or every slot when full; cancel
// does not scan; tick scans every slot. A word is held in the response
// register while the receiver holds rsp_stall; the scan waits on a full
// response register and resumes where it stopped. Reset clears the count,
// the busy bits and the response valid bit; slot contents need no clearing.
module timer_slot_pool_unit
   import tsp_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [TICK_W-1:0]    req_tick_delay,
   input  logic [SLOT_W-1:0]    req_slot_to_cancel,
   input  logic [HANDLER_W-1:0] req_handler_id,
   input  logic [TAG_W-1:0]     req_user_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic                 rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [HANDLER_W-1:0] rsp_expired_handler,
   output logic [TAG_W-1:0]     rsp_expired_tag,
   output logic                 rsp_last
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;

   // Latched request payload
   logic [TICK_W-1:0]    delay_ff;
   logic [SLOT_W-1:0]    cancel_ff;
   logic [HANDLER_W-1:0] handler_ff;
   logic [TAG_W-1:0]     tag_ff;

   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff;
   logic         rsp_load;

   logic           req_accept;
   logic           out_free;
   logic           at_last;
   logic           slot_free;
   logic           scan_hit;
   logic           cancel_hit;
   logic           busy_set, busy_clr;
   logic [IDX_W-1:0] busy_idx;
   logic           wr_en;
   slot_entry_type wr_data;
   slot_entry_type rd_data;

   // Slot storage; read address follows the next scan index
   tsp_slot_store #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (idx_ff),
      .wr_data (wr_data),
      .rd_idx  (idx_in),
      .rd_data (rd_data)
   );

   // Shared conditions
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign at_last    = (idx_ff == LAST_IDX);
   assign slot_free  = !busy_ff[idx_ff];
   assign scan_hit   = busy_ff[idx_ff] && (rd_data.expiry == tick_ff);
   assign cancel_hit = ({1'b0, cancel_ff} < (SLOT_W + 1)'(SLOT_COUNT));

   assign wr_data.expiry  = tick_ff + delay_ff;
   assign wr_data.handler = handler_ff;
   assign wr_data.tag     = tag_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_START:  state_in = ST_START;
                  OP_CANCEL: state_in = ST_CANCEL;
                  OP_TICK:   state_in = ST_TICK_SCAN;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_START: begin
            if (out_free && (slot_free || at_last)) begin
               state_in = ST_IDLE;
            end
         end
         ST_CANCEL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_SCAN: begin
            if (at_last && (!scan_hit || out_free)) begin
               state_in = ST_TICK_DONE;
            end
         end
         ST_TICK_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      idx_in   = '0;
      rsp_load = 1'b0;
      rsp_in   = '0;
      busy_set = 1'b0;
      busy_clr = 1'b0;
      busy_idx = idx_ff;
      wr_en    = 1'b0;
      tick_in  = tick_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_opcode == OP_TICK)) begin
               tick_in = tick_ff + TICK_W'(1);
            end
         end
         ST_START: begin
            idx_in = idx_ff;
            if (slot_free) begin
               if (out_free) begin
                  wr_en       = 1'b1;
                  busy_set    = 1'b1;
                  rsp_load    = 1'b1;
                  rsp_in.kind = KIND_START;
                  rsp_in.slot = SLOT_W'(idx_ff);
                  rsp_in.last = 1'b1;
                  idx_in      = '0;
               end
            end else if (at_last) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_in.kind   = KIND_START;
                  rsp_in.status = STATUS_NO_SLOT;
                  rsp_in.last   = 1'b1;
                  idx_in        = '0;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_CANCEL: begin
            busy_idx = cancel_ff[IDX_W-1:0];
            if (out_free) begin
               busy_clr    = cancel_hit;
               rsp_load    = 1'b1;
               rsp_in.kind = KIND_CANCEL;
               rsp_in.last = 1'b1;
            end
         end
         ST_TICK_SCAN: begin
            if (scan_hit && !out_free) begin
               idx_in = idx_ff;
            end else begin
               idx_in = at_last ? '0 : idx_ff + IDX_W'(1);
            end
            if (scan_hit && out_free) begin
               busy_clr       = 1'b1;
               rsp_load       = 1'b1;
               rsp_in.kind    = KIND_EXPIRY;
               rsp_in.slot    = SLOT_W'(idx_ff);
               rsp_in.handler = rd_data.handler;
               rsp_in.tag     = rd_data.tag;
            end
         end
         ST_TICK_DONE: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_in.kind = KIND_TICK;
               rsp_in.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Busy bit update
   always_comb begin
      busy_in = busy_ff;
      if (busy_set) begin
         busy_in[busy_idx] = 1'b1;
      end
      if (busy_clr) begin
         busy_in[busy_idx] = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         busy_ff      <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         busy_ff  <= busy_in;
         tick_ff  <= tick_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         delay_ff   <= req_tick_delay;
         cancel_ff  <= req_slot_to_cancel;
         handler_ff <= req_handler_id;
         tag_ff     <= req_user_tag;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_ff.kind;
   assign rsp_status          = rsp_ff.status;
   assign rsp_slot            = rsp_ff.slot;
   assign rsp_expired_handler = rsp_ff.handler;
   assign rsp_expired_tag     = rsp_ff.tag;
   assign rsp_last            = rsp_ff.last;

   // Checks
   a_tick_advance : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == OP_TICK)) |=> (tick_ff == $past(tick_ff) + TICK_W'(1)))
      else $error("tick count did not advance on a tick word");

   a_no_slot_only_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.status) |-> (&busy_ff))
      else $error("no-slot status while a slot is free");

   a_grant_takes_slot : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (rsp_in.kind == KIND_START) && !rsp_in.status)
      |=> ($countones(busy_ff) == $past($countones(busy_ff)) + 1))
      else $error("granted slot not marked busy");

   a_expiry_frees_slot : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (rsp_in.kind == KIND_EXPIRY))
      |=> ($countones(busy_ff) + 1 == $past($countones(busy_ff))))
      else $error("expired slot not freed");

   a_expiry_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (rsp_in.kind == KIND_EXPIRY)) |-> !rsp_in.last)
      else $error("expiry word marked last");

endmodule

// ===== hw/rtl/tsp_slot_store.sv =====
// Slot storage: expiry, handler and tag per slot, one write and one registered read.
module tsp_slot_store
   import tsp_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  slot_entry_type          wr_data,
   input  logic [IDX_W-1:0]        rd_idx,
   output slot_entry_type          rd_data
);

   slot_entry_type mem [SLOT_COUNT];
   slot_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb_timer_slot_pool_unit.sv =====
// Self-checking testbench for the timer slot pool: directed plan, random traffic, scoreboard.
`timescale 1ns / 100ps

module tb_timer_slot_pool_unit;
   import tsp_pkg::*;

   localparam int POOL_SLOTS   = SLOT_COUNT_DEF;
   localparam int ITEM_TARGET  = 410;
   localparam int PLAN_ROWS    = 10 + POOL_SLOTS;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT_ITEM = 120;
   localparam int DRAIN_CYCLES = 2 * POOL_SLOTS + 8;
   localparam int IDLE_PCT     = 22;
   localparam int MAX_PRINTED  = 50;

   // The one opcode the block takes and drops
   localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;

   // How a plan row is checked
   typedef enum logic [1:0] {
      ROW_CHECK_MODEL,
      ROW_CHECK_ONE,
      ROW_CHECK_NONE
   } row_check_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [TICK_W-1:0]    delay;
      logic [SLOT_W-1:0]    cancel_slot;
      logic [HANDLER_W-1:0] handler;
      logic [TAG_W-1:0]     tag;
   } timer_req_type;

   typedef struct {
      timer_req_type rq;
      row_check_type check;
      rsp_word_type  want;
   } plan_row_type;

   logic                 clock;
   logic                 reset              = 1'b1;
   logic                 req_valid          = 1'b0;
   logic                 req_stall;
   logic [OPCODE_W-1:0]  req_opcode         = '0;
   logic [TICK_W-1:0]    req_tick_delay     = '0;
   logic [SLOT_W-1:0]    req_slot_to_cancel = '0;
   logic [HANDLER_W-1:0] req_handler_id     = '0;
   logic [TAG_W-1:0]     req_user_tag       = '0;
   logic                 rsp_valid;
   logic                 rsp_stall          = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic                 rsp_status;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [HANDLER_W-1:0] rsp_expired_handler;
   logic [TAG_W-1:0]     rsp_expired_tag;
   logic                 rsp_last;

   // Predictor copy of the pool
   logic [TICK_W-1:0]    pool_ticks;
   logic                 pool_busy    [POOL_SLOTS];
   logic [TICK_W-1:0]    pool_expiry  [POOL_SLOTS];
   logic [HANDLER_W-1:0] pool_handler [POOL_SLOTS];
   logic [TAG_W-1:0]     pool_tag     [POOL_SLOTS];

   rsp_word_type fresh_words[$];
   rsp_word_type pending_words[$];

   int  errors_seen    = 0;
   int  words_checked  = 0;
   int  items_done     = 0;
   int  starts_granted = 0;
   int  starts_refused = 0;
   int  cancels_done   = 0;
   int  ticks_done     = 0;
   int  expiries_seen  = 0;
   int  widest_tick    = 0;
   logic quiet_run;

   // Stretch with no idling on either side
   assign quiet_run = (items_done >= 250 && items_done < 320);

   timer_slot_pool_unit #(
      .SLOT_COUNT(POOL_SLOTS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_tick_delay      (req_tick_delay),
      .req_slot_to_cancel  (req_slot_to_cancel),
      .req_handler_id      (req_handler_id),
      .req_user_tag        (req_user_tag),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_expired_handler (rsp_expired_handler),
      .rsp_expired_tag     (rsp_expired_tag),
      .rsp_last            (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_word_type make_word(input logic [KIND_W-1:0] kind,
                                              input logic status,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [HANDLER_W-1:0] handler,
                                              input logic [TAG_W-1:0] tag,
                                              input logic last);
      rsp_word_type w;
      w.kind    = kind;
      w.status  = status;
      w.slot    = slot;
      w.handler = handler;
      w.tag     = tag;
      w.last    = last;
      return w;
   endfunction

   function automatic plan_row_type mk_row(input logic [OPCODE_W-1:0] op,
                                           input logic [TICK_W-1:0] delay,
                                           input logic [SLOT_W-1:0] cslot,
                                           input logic [HANDLER_W-1:0] handler,
                                           input logic [TAG_W-1:0] tag,
                                           input row_check_type check,
                                           input rsp_word_type want);
      plan_row_type r;
      r.rq.opcode      = op;
      r.rq.delay       = delay;
      r.rq.cancel_slot = cslot;
      r.rq.handler     = handler;
      r.rq.tag         = tag;
      r.check          = check;
      r.want           = want;
      return r;
   endfunction

   // Random request; delays lean short so timers actually fire
   function automatic timer_req_type draw_request(input logic [OPCODE_W-1:0] op);
      timer_req_type rq;
      int pick;
      rq.opcode  = op;
      rq.handler = HANDLER_W'($urandom);
      rq.tag     = $urandom;
      pick = $urandom_range(99);
      if (pick < 70)
         rq.delay = TICK_W'($urandom_range(1, 10));
      else if (pick < 80)
         rq.delay = '0;
      else if (pick < 88)
         rq.delay = '1;
      else
         rq.delay = TICK_W'($urandom);
      if ($urandom_range(99) < 75)
         rq.cancel_slot = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
      else
         rq.cancel_slot = SLOT_W'($urandom_range(POOL_SLOTS, 63));
      return rq;
   endfunction

   // Pool behavior: one request in, its response words into fresh_words
   task automatic step_pool(input timer_req_type rq);
      int i;
      int grant;
      int fired;
      fresh_words.delete();
      case (rq.opcode)
         OP_START: begin
            grant = -1;
            for (i = 0; i < POOL_SLOTS; i++)
               if (grant < 0 && !pool_busy[i]) grant = i;
            if (grant >= 0) begin
               pool_busy[grant]    = 1'b1;
               pool_expiry[grant]  = pool_ticks + rq.delay;
               pool_handler[grant] = rq.handler;
               pool_tag[grant]     = rq.tag;
               fresh_words.push_back(make_word(KIND_START, STATUS_OK, SLOT_W'(grant),
                                               '0, '0, 1'b1));
               starts_granted++;
            end else begin
               fresh_words.push_back(make_word(KIND_START, STATUS_NO_SLOT, '0, '0, '0, 1'b1));
               starts_refused++;
            end
         end
         OP_CANCEL: begin
            if (rq.cancel_slot < POOL_SLOTS && pool_busy[rq.cancel_slot]) begin
               pool_busy[rq.cancel_slot]   = 1'b0;
               pool_expiry[rq.cancel_slot] = '0;
            end
            fresh_words.push_back(make_word(KIND_CANCEL, STATUS_OK, '0, '0, '0, 1'b1));
            cancels_done++;
         end
         OP_TICK: begin
            pool_ticks = pool_ticks + TICK_W'(1);
            fired = 0;
            for (i = 0; i < POOL_SLOTS; i++) begin
               if (pool_busy[i] && pool_expiry[i] == pool_ticks) begin
                  pool_busy[i]   = 1'b0;
                  pool_expiry[i] = '0;
                  fresh_words.push_back(make_word(KIND_EXPIRY, STATUS_OK, SLOT_W'(i),
                                                  pool_handler[i], pool_tag[i], 1'b0));
                  fired++;
               end
            end
            fresh_words.push_back(make_word(KIND_TICK, STATUS_OK, '0, '0, '0, 1'b1));
            ticks_done++;
            expiries_seen += fired;
            if (fired > widest_tick) widest_tick = fired;
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [TAG_W-1:0] want,
                                  input logic [TAG_W-1:0] got);
      errors_seen++;
      if (errors_seen <= MAX_PRINTED)
         $display("ERROR t=%0t word %0d %s: want %0h got %0h", $time, words_checked,
                  what, want, got);
   endtask

   // Offer one request word, wait for the handshake, then book its responses
   task automatic offer_item(input timer_req_type rq, input row_check_type check,
                             input rsp_word_type want);
      int gap;
      if (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= rq.opcode;
      req_tick_delay     <= rq.delay;
      req_slot_to_cancel <= rq.cancel_slot;
      req_handler_id     <= rq.handler;
      req_user_tag       <= rq.tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_pool(rq);
      case (check)
         ROW_CHECK_MODEL: foreach (fresh_words[k]) pending_words.push_back(fresh_words[k]);
         ROW_CHECK_ONE:   pending_words.push_back(want);
         default: ;
      endcase
      if (rq.opcode != OP_IGNORED) items_done++;
   endtask

   // Receiver: random stalls, one long hold-off, a quiet stretch
   int  hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_done >= HOLD_AT_ITEM) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !quiet_run && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Scoreboard: each accepted response word against the oldest pending one
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with none pending, kind", '0, TAG_W'(rsp_kind));
         end else begin
            want = pending_words.pop_front();
            if (rsp_kind != want.kind)
               report_mismatch("kind", TAG_W'(want.kind), TAG_W'(rsp_kind));
            if (rsp_status != want.status)
               report_mismatch("status", TAG_W'(want.status), TAG_W'(rsp_status));
            if (rsp_slot != want.slot)
               report_mismatch("slot", TAG_W'(want.slot), TAG_W'(rsp_slot));
            if (rsp_expired_handler != want.handler)
               report_mismatch("handler", TAG_W'(want.handler), TAG_W'(rsp_expired_handler));
            if (rsp_expired_tag != want.tag) report_mismatch("tag", want.tag, rsp_expired_tag);
            if (rsp_last != want.last)
               report_mismatch("last", TAG_W'(want.last), TAG_W'(rsp_last));
         end
         words_checked++;
      end
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("ERROR timeout with %0d words still pending", pending_words.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      plan_row_type plan [PLAN_ROWS];
      rsp_word_type cancel_ok;
      logic [OPCODE_W-1:0] op;
      int n;
      int pick;
      int burst;

      pool_ticks = '0;
      for (n = 0; n < POOL_SLOTS; n++) begin
         pool_busy[n]    = 1'b0;
         pool_expiry[n]  = '0;
         pool_handler[n] = '0;
         pool_tag[n]     = '0;
      end

      // Directed plan: extremes, every opcode, the corner cases
      cancel_ok = make_word(KIND_CANCEL, STATUS_OK, '0, '0, '0, 1'b1);
      plan[0] = mk_row(OP_START, 16'd1, '1, '1, '1, ROW_CHECK_ONE,
                       make_word(KIND_START, STATUS_OK, 6'd0, '0, '0, 1'b1));
      // fires slot 0 with all-ones handler and tag
      plan[1] = mk_row(OP_TICK, '0, '0, '0, '0, ROW_CHECK_MODEL, '0);
      // zero delay means a full wrap of the counter
      plan[2] = mk_row(OP_START, '0, '0, '0, '0, ROW_CHECK_ONE,
                       make_word(KIND_START, STATUS_OK, 6'd0, '0, '0, 1'b1));
      plan[3] = mk_row(OP_CANCEL, '1, 6'd0, '0, '0, ROW_CHECK_ONE, cancel_ok);
      // cancel of a free slot, then of a slot past the pool
      plan[4] = mk_row(OP_CANCEL, '0, 6'd7, '0, '0, ROW_CHECK_ONE, cancel_ok);
      plan[5] = mk_row(OP_CANCEL, '0, '1, '1, '1, ROW_CHECK_ONE, cancel_ok);
      plan[6] = mk_row(OP_IGNORED, '1, '1, '1, '1, ROW_CHECK_NONE, '0);
      // fill every slot, all due on the same tick
      for (n = 0; n < POOL_SLOTS; n++)
         plan[7 + n] = mk_row(OP_START, 16'd2, SLOT_W'($urandom), HANDLER_W'(n * 17),
                              $urandom, ROW_CHECK_ONE,
                              make_word(KIND_START, STATUS_OK, SLOT_W'(n), '0, '0, 1'b1));
      plan[7 + POOL_SLOTS] = mk_row(OP_START, 16'd5, '0, 8'h3C, 32'h1234_5678,
                                    ROW_CHECK_ONE,
                                    make_word(KIND_START, STATUS_NO_SLOT, '0, '0, '0, 1'b1));
      plan[8 + POOL_SLOTS] = mk_row(OP_TICK, '0, '0, '0, '0, ROW_CHECK_MODEL, '0);
      plan[9 + POOL_SLOTS] = mk_row(OP_TICK, '1, '1, '1, '1, ROW_CHECK_MODEL, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < PLAN_ROWS; n++)
         offer_item(plan[n].rq, plan[n].check, plan[n].want);

      // Random traffic: mostly single requests, some start bursts to fill the pool
      while (items_done < ITEM_TARGET) begin
         if ($urandom_range(99) < 10) begin
            burst = $urandom_range(4, POOL_SLOTS + 2);
            repeat (burst) offer_item(draw_request(OP_START), ROW_CHECK_MODEL, '0);
         end else begin
            pick = $urandom_range(99);
            if (pick < 38)      op = OP_START;
            else if (pick < 58) op = OP_CANCEL;
            else if (pick < 95) op = OP_TICK;
            else                op = OP_IGNORED;
            offer_item(draw_request(op), ROW_CHECK_MODEL, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d starts granted, %0d refused, %0d cancels, %0d ticks",
               items_done, starts_granted, starts_refused, cancels_done, ticks_done);
      $display("%0d timers fired (up to %0d on one tick), %0d response words checked",
               expiries_seen, widest_tick, words_checked);
      if (errors_seen == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_slot_store.sv
hw/rtl/timer_slot_pool_unit.sv
tb/sv/tb_timer_slot_pool_unit.sv
